// File: rtl/sfs_pkg.sv
// Shared widths, codes and controller/datapath handshake types for the frame sequencer.
`timescale 1ns / 1ps
package sfs_pkg;

  localparam int MAX_FRAMES = 64;
  localparam int TIME_W     = 24;
  localparam int FRAME_W    = 7;
  localparam int IDX_W      = 6;
  localparam int DELTA_W    = 16;
  localparam int SPEED_W    = 12;
  localparam int PROD_W     = DELTA_W + SPEED_W;
  localparam int SPEED_FRAC = 8;
  localparam int SCALED_W   = PROD_W - SPEED_FRAC;
  localparam int SUM_W      = TIME_W + 1;
  localparam int DIV_CNT_W  = $clog2(SUM_W + 1);
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  localparam logic [TIME_W-1:0]  TIME_TOP      = {TIME_W{1'b1}};
  localparam logic [SPEED_W-1:0] SPEED_UNITY   = SPEED_W'(256);

  typedef enum logic [1:0] {
    KIND_TICK    = 2'd0,
    KIND_WRITE   = 2'd1,
    KIND_CUE     = 2'd2,
    KIND_ADVANCE = 2'd3
  } kind_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DURATION    = 3'd0,
    CFG_PLAY_SPEED  = 3'd1,
    CFG_LOOP_ENABLE = 3'd2,
    CFG_PAUSE       = 3'd3,
    CFG_FRAME_COUNT = 3'd4
  } cfg_idx_t;

  typedef struct packed {
    logic capture;
    logic write_entry;
    logic cue;
    logic advance;
    logic mul;
    logic add;
    logic settle_time;
    logic div_start_time;
    logic div_start_frame;
    logic div_step;
    logic div_finish;
    logic scan_start;
    logic scan_step;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    kind_t kind;
    logic  tick_live;
    logic  adv_wrap;
    logic  div_wrap;
    logic  div_done;
    logic  div_for_frame;
    logic  scan_done;
    logic  out_free;
  } status_t;

endpackage

// File: rtl/sfs_if.sv
// Input and result channel interfaces of the frame sequencer.
`timescale 1ns / 1ps
interface sfs_in_if;
  import sfs_pkg::*;
  logic               valid;
  logic               ready;
  logic [1:0]         kind;
  logic [DELTA_W-1:0] delta;
  logic [IDX_W-1:0]   entry_index;
  logic [TIME_W-1:0]  entry_time;

  modport source (output valid, kind, delta, entry_index, entry_time, input ready);
  modport sink (input valid, kind, delta, entry_index, entry_time, output ready);
endinterface

interface sfs_out_if;
  import sfs_pkg::*;
  logic              valid;
  logic              ready;
  logic [IDX_W-1:0]  frame_index;
  logic [TIME_W-1:0] time_now;
  logic              finished;

  modport source (output valid, frame_index, time_now, finished, input ready);
  modport sink (input valid, frame_index, time_now, finished, output ready);
endinterface

// File: rtl/sprite_frame_sequencer_top.sv
// Top level of the sprite animation frame sequencer.
`timescale 1ns / 1ps
// Each input transfer yields exactly one result transfer. A table write, a cue or an
// advance goes from dispatch straight to the result register; an advance that wraps
// past the last frame first passes through the shared remainder unit. A live tick
// scales the delta, adds it, clamps or wraps the time and then runs the first-match
// scan over the table entries until it hits (one table read per cycle through the
// registered memory port); a looping time that wraps passes through the remainder
// unit before the scan. The next item is accepted as soon as the previous result
// sits in the output register, even if it has not been taken yet.
// There is no clearing pass after reset; table entries are valid once written.
module sprite_frame_sequencer_top (
  input  logic                           clk,
  input  logic                           rst,
  sfs_in_if.sink                         item_in,
  sfs_out_if.source                      result_out,
  input  logic                           cfg_we,
  input  logic [sfs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [sfs_pkg::CFG_DATA_W-1:0] cfg_data
);
  import sfs_pkg::*;

  cmd_t    cmd;
  status_t status;

  sfs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (item_in.valid),
    .in_ready (item_in.ready),
    .status   (status),
    .cmd      (cmd)
  );

  sfs_datapath u_datapath (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .status          (status),
    .in_kind         (item_in.kind),
    .in_delta        (item_in.delta),
    .in_entry_index  (item_in.entry_index),
    .in_entry_time   (item_in.entry_time),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .out_valid       (result_out.valid),
    .out_ready       (result_out.ready),
    .out_frame_index (result_out.frame_index),
    .out_time_now    (result_out.time_now),
    .out_finished    (result_out.finished)
  );

endmodule

// File: rtl/sfs_ctrl.sv
// Controller state machine that sequences one item through the datapath.
`timescale 1ns / 1ps
module sfs_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  sfs_pkg::status_t status,
  output sfs_pkg::cmd_t    cmd
);
  import sfs_pkg::*;

  typedef enum logic [7:0] {
    ST_IDLE     = 8'b0000_0001,
    ST_DISPATCH = 8'b0000_0010,
    ST_MUL      = 8'b0000_0100,
    ST_ADD      = 8'b0000_1000,
    ST_CLAMP    = 8'b0001_0000,
    ST_DIV      = 8'b0010_0000,
    ST_SCAN     = 8'b0100_0000,
    ST_DONE     = 8'b1000_0000
  } state_t;

  state_t state;
  state_t state_next;

  assign in_ready = (state == ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        case (status.kind)
          KIND_TICK: begin
            state_next = status.tick_live ? ST_MUL : ST_DONE;
          end
          KIND_WRITE: begin
            cmd.write_entry = 1'b1;
            state_next      = ST_DONE;
          end
          KIND_CUE: begin
            cmd.cue    = 1'b1;
            state_next = ST_DONE;
          end
          KIND_ADVANCE: begin
            if (status.adv_wrap) begin
              cmd.div_start_frame = 1'b1;
              state_next          = ST_DIV;
            end else begin
              cmd.advance = 1'b1;
              state_next  = ST_DONE;
            end
          end
          default: state_next = ST_DONE;
        endcase
      end
      ST_MUL: begin
        cmd.mul    = 1'b1;
        state_next = ST_ADD;
      end
      ST_ADD: begin
        cmd.add    = 1'b1;
        state_next = ST_CLAMP;
      end
      ST_CLAMP: begin
        if (status.div_wrap) begin
          cmd.div_start_time = 1'b1;
          state_next         = ST_DIV;
        end else begin
          cmd.settle_time = 1'b1;
          cmd.scan_start  = 1'b1;
          state_next      = ST_SCAN;
        end
      end
      ST_DIV: begin
        if (status.div_done) begin
          cmd.div_finish = 1'b1;
          if (status.div_for_frame) begin
            state_next = ST_DONE;
          end else begin
            cmd.scan_start = 1'b1;
            state_next     = ST_SCAN;
          end
        end else begin
          cmd.div_step = 1'b1;
        end
      end
      ST_SCAN: begin
        cmd.scan_step = 1'b1;
        if (status.scan_done) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // The divider must run its full count before the controller moves on.
  a_div_holds: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV) && !status.div_done |=> (state == ST_DIV))
    else $error("controller left the divide state early");

endmodule

// File: rtl/sfs_datapath.sv
// Datapath: configuration, time and frame state, scaler, divider, frame table scan, result.
`timescale 1ns / 1ps
module sfs_datapath (
  input  logic                           clk,
  input  logic                           rst,
  input  sfs_pkg::cmd_t                  cmd,
  output sfs_pkg::status_t               status,
  input  logic [1:0]                     in_kind,
  input  logic [sfs_pkg::DELTA_W-1:0]    in_delta,
  input  logic [sfs_pkg::IDX_W-1:0]      in_entry_index,
  input  logic [sfs_pkg::TIME_W-1:0]     in_entry_time,
  input  logic                           cfg_we,
  input  logic [sfs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [sfs_pkg::CFG_DATA_W-1:0] cfg_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [sfs_pkg::IDX_W-1:0]      out_frame_index,
  output logic [sfs_pkg::TIME_W-1:0]     out_time_now,
  output logic                           out_finished
);
  import sfs_pkg::*;

  localparam int AW = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;

  // Configuration registers.
  logic [TIME_W-1:0]  duration;
  logic [SPEED_W-1:0] play_speed;
  logic               loop_enable;
  logic               pause;
  logic [FRAME_W-1:0] frame_count;

  // Captured item.
  kind_t              kind_q;
  logic [DELTA_W-1:0] delta_q;
  logic [IDX_W-1:0]   entry_q;
  logic [TIME_W-1:0]  etime_q;

  // Sequencer state.
  logic [TIME_W-1:0]  elapsed;
  logic [FRAME_W-1:0] cur_frame;

  // Tick arithmetic.
  logic [SCALED_W-1:0] scaled;
  logic [SUM_W-1:0]    sum;

  // Restoring divider, one quotient bit per cycle; only the remainder is kept.
  logic [SUM_W-1:0]     div_num;
  logic [TIME_W-1:0]    div_den;
  logic [TIME_W-1:0]    div_rem;
  logic [DIV_CNT_W-1:0] div_cnt;
  logic                 div_for_frame;
  logic [SUM_W-1:0]     div_trial;

  // Frame table and its scan.
  logic [TIME_W-1:0]  frame_mem [MAX_FRAMES];
  logic [TIME_W-1:0]  rd_data;
  logic [FRAME_W-1:0] rd_idx;
  logic [FRAME_W-1:0] cmp_idx;
  logic               cmp_valid;
  logic               cmp_hit;
  logic               cmp_last;
  logic               scan_done;

  logic [FRAME_W-1:0] n_use;
  logic [FRAME_W:0]   cur_plus;
  logic               adv_inc;
  logic               write_ok;
  logic [PROD_W-1:0]  prod;

  always_comb begin
    n_use = (32'(frame_count) > MAX_FRAMES) ? FRAME_W'(MAX_FRAMES) : frame_count;
  end

  assign cur_plus  = {1'b0, cur_frame} + (FRAME_W + 1)'(1);
  assign adv_inc   = (n_use != '0) && (cur_plus < {1'b0, n_use});
  assign write_ok  = 32'(entry_q) < MAX_FRAMES;
  assign prod      = PROD_W'(delta_q) * PROD_W'(play_speed);
  assign div_trial = {div_rem, div_num[SUM_W-1]};
  assign cmp_hit   = cmp_valid && (elapsed <= rd_data);
  assign cmp_last  = ({1'b0, cmp_idx} + (FRAME_W + 1)'(1)) == {1'b0, n_use};
  assign scan_done = cmp_valid && (cmp_hit || cmp_last);

  always_comb begin
    status               = '0;
    status.kind          = kind_q;
    status.tick_live     = (frame_count != '0) && !pause;
    status.adv_wrap      = (n_use != '0) && !adv_inc && loop_enable;
    status.div_wrap      = loop_enable && (sum >= {1'b0, duration}) && (duration != '0);
    status.div_done      = (div_cnt == '0);
    status.div_for_frame = div_for_frame;
    status.scan_done     = scan_done;
    status.out_free      = !out_valid || out_ready;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      duration    <= '0;
      play_speed  <= SPEED_UNITY;
      loop_enable <= 1'b0;
      pause       <= 1'b0;
      frame_count <= '0;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_DURATION:    duration    <= cfg_data[TIME_W-1:0];
        CFG_PLAY_SPEED:  play_speed  <= cfg_data[SPEED_W-1:0];
        CFG_LOOP_ENABLE: loop_enable <= cfg_data[0];
        CFG_PAUSE:       pause       <= cfg_data[0];
        CFG_FRAME_COUNT: frame_count <= cfg_data[FRAME_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      kind_q  <= kind_t'(in_kind);
      delta_q <= in_delta;
      entry_q <= in_entry_index;
      etime_q <= in_entry_time;
    end
    if (cmd.mul) begin
      scaled <= prod[PROD_W-1:SPEED_FRAC];
    end
    if (cmd.add) begin
      sum <= SUM_W'(elapsed) + SUM_W'(scaled);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      elapsed   <= '0;
      cur_frame <= '0;
    end else begin
      if (cmd.cue) begin
        elapsed   <= '0;
        cur_frame <= '0;
      end
      if (cmd.advance && adv_inc) begin
        cur_frame <= cur_plus[FRAME_W-1:0];
      end
      if (cmd.settle_time) begin
        if (loop_enable) begin
          // Only a zero duration reaches here with the sum past the end.
          elapsed <= (sum >= {1'b0, duration}) ? '0 : sum[TIME_W-1:0];
        end else begin
          elapsed <= sum[SUM_W-1] ? TIME_TOP : sum[TIME_W-1:0];
        end
      end
      if (cmd.div_finish) begin
        if (div_for_frame) begin
          cur_frame <= div_rem[FRAME_W-1:0];
        end else begin
          elapsed <= div_rem;
        end
      end
      if (cmd.scan_step && scan_done) begin
        cur_frame <= cmp_hit ? cmp_idx : '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      div_cnt       <= '0;
      div_for_frame <= 1'b0;
    end else if (cmd.div_start_time || cmd.div_start_frame) begin
      div_cnt       <= DIV_CNT_W'(SUM_W);
      div_for_frame <= cmd.div_start_frame;
    end else if (cmd.div_step) begin
      div_cnt <= div_cnt - DIV_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_start_time) begin
      div_num <= sum;
      div_den <= duration;
      div_rem <= '0;
    end else if (cmd.div_start_frame) begin
      div_num <= SUM_W'(cur_plus);
      div_den <= TIME_W'(n_use);
      div_rem <= '0;
    end else if (cmd.div_step) begin
      div_num <= {div_num[SUM_W-2:0], 1'b0};
      if (div_trial >= {1'b0, div_den}) begin
        div_rem <= TIME_W'(div_trial - {1'b0, div_den});
      end else begin
        div_rem <= div_trial[TIME_W-1:0];
      end
    end
  end

  // Table write port and the registered read port used by the scan.
  always_ff @(posedge clk) begin
    if (cmd.write_entry && write_ok) begin
      frame_mem[AW'(entry_q)] <= etime_q;
    end
    rd_data <= frame_mem[AW'(rd_idx)];
  end

  // The read address runs one entry ahead of the compare stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      cmp_valid <= 1'b0;
      rd_idx    <= '0;
    end else if (cmd.scan_start) begin
      cmp_valid <= 1'b0;
      rd_idx    <= '0;
    end else if (cmd.scan_step) begin
      if (rd_idx < n_use) begin
        cmp_valid <= 1'b1;
        rd_idx    <= rd_idx + FRAME_W'(1);
      end else begin
        cmp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_step && (rd_idx < n_use)) begin
      cmp_idx <= rd_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_frame_index <= cur_frame[IDX_W-1:0];
      out_time_now    <= elapsed;
      out_finished    <= (frame_count != '0) && !loop_enable && (elapsed >= duration);
    end
  end

  a_out_free: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (!out_valid || out_ready))
    else $error("result loaded over one not yet transferred");

  a_scan_in_range: assert property (@(posedge clk) disable iff (rst)
    cmd.scan_step && scan_done |=> (cur_frame < n_use))
    else $error("scan produced a frame outside the track");

  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    (div_cnt != '0) |-> (div_rem < div_den))
    else $error("divider remainder reached the divisor");

endmodule
